// ===== hw/rtl/slbs_pkg.sv =====
// Shared types and constants for the status LED blink sequencer.
// No dependencies; imported by slbs_core and status_led_blink_sequencer.
`default_nettype none

package slbs_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CYCLE_W        = 16;
  localparam int NUM_LEDS       = 3;

  // LED index
  localparam logic [1:0] LED_GCS  = 2'd0;
  localparam logic [1:0] LED_WIFI = 2'd1;
  localparam logic [1:0] LED_AIR  = 2'd2;

  // LED modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_BLINK  = 2'd2;
  localparam logic [1:0] MODE_DOUBLE = 2'd3;

  // Request kinds
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [7:0] PIXEL_ON = 8'd150;

  // Short double-blink steps before the long gap
  localparam logic [1:0] SHORT_COUNT = 2'd3;

  // x/3 for 16-bit x: (x * RECIP3) >> RECIP3_SH, exact over the full range
  localparam logic [16:0] RECIP3    = 17'h0AAAB;
  localparam int          RECIP3_SH = 17;

  // Register indexes
  localparam logic REG_CYCLE_TIME = 1'b0;
  localparam logic REG_RGB_MODE   = 1'b1;

  // One result, gcs_pin in bit 0
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       air_pin;
    logic       wifi_pin;
    logic       gcs_pin;
  } slbs_result_t;

  // Configuration seen by the core
  typedef struct packed {
    logic [CYCLE_W-1:0] cycle_time;
    logic [CYCLE_W-1:0] third;
    logic               rgb_mode;
  } slbs_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slbs_core.sv =====
// LED mode/level state, blink and double-blink countdowns, result formatting.
// Depends on slbs_pkg.
`default_nettype none

module slbs_core #(
  parameter int TIMER_BITS = slbs_pkg::TIMER_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_fire,
  input  wire logic                 req_type,
  input  wire logic [1:0]           led_select,
  input  wire logic [1:0]           led_mode,
  input  wire slbs_pkg::slbs_cfg_t  cfg,
  output slbs_pkg::slbs_result_t    result
);
  import slbs_pkg::*;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [1:0]            mode_r  [NUM_LEDS];
  logic [1:0]            mode_nxt[NUM_LEDS];
  logic [NUM_LEDS-1:0]   level_r, level_nxt;
  logic [TIMER_BITS-1:0] blink_wait_r, blink_wait_nxt, blink_dec;
  logic [TIMER_BITS-1:0] pat_wait_r, pat_wait_nxt, pat_dec;
  logic [1:0]            pat_step_r, pat_step_nxt;
  logic [32:0]           full_ext, third_ext;
  logic [TIMER_BITS-1:0] load_full, load_third;
  logic                  wifi_act, gcs_act, air_act;

  // Reload values, saturated to the countdown width
  always_comb begin
    full_ext   = {17'd0, cfg.cycle_time};
    third_ext  = {17'd0, cfg.third};
    load_full  = (full_ext > TMAX)  ? TMAX[TIMER_BITS-1:0] : full_ext[TIMER_BITS-1:0];
    load_third = (third_ext > TMAX) ? TMAX[TIMER_BITS-1:0] : third_ext[TIMER_BITS-1:0];
  end

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      mode_nxt[i] = mode_r[i];
    end
    level_nxt      = level_r;
    blink_wait_nxt = blink_wait_r;
    pat_wait_nxt   = pat_wait_r;
    pat_step_nxt   = pat_step_r;
    blink_dec      = (blink_wait_r != '0) ? blink_wait_r - 1'b1 : blink_wait_r;
    pat_dec        = (pat_wait_r != '0) ? pat_wait_r - 1'b1 : pat_wait_r;

    if (req_type == REQ_SET) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (led_select == 2'(i) && mode_r[i] != led_mode) begin
          mode_nxt[i] = led_mode;
          if (led_mode == MODE_OFF) begin
            level_nxt[i] = 1'b0;
          end else if (led_mode == MODE_ON) begin
            level_nxt[i] = 1'b1;
          end else if (led_mode == MODE_DOUBLE && 2'(i) == LED_WIFI) begin
            level_nxt[i] = 1'b0;
          end
        end
      end
    end else begin
      // blink timer
      blink_wait_nxt = blink_dec;
      if (blink_dec == '0) begin
        blink_wait_nxt = load_full;
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (mode_r[i] == MODE_BLINK) begin
            level_nxt[i] = ~level_nxt[i];
          end
        end
      end
      // double-blink pattern, free running
      pat_wait_nxt = pat_dec;
      if (pat_dec == '0) begin
        if (pat_step_r < SHORT_COUNT) begin
          pat_step_nxt = pat_step_r + 2'd1;
          pat_wait_nxt = load_third;
        end else begin
          pat_step_nxt = 2'd0;
          pat_wait_nxt = load_full;
        end
        if (mode_r[LED_WIFI] == MODE_DOUBLE) begin
          level_nxt[LED_WIFI] = ~level_nxt[LED_WIFI];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_r[i] <= MODE_OFF;
      end
      level_r      <= '0;
      blink_wait_r <= '0;
      pat_wait_r   <= '0;
      pat_step_r   <= 2'd0;
    end else if (req_fire) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_r[i] <= mode_nxt[i];
      end
      level_r      <= level_nxt;
      blink_wait_r <= blink_wait_nxt;
      pat_wait_r   <= pat_wait_nxt;
      pat_step_r   <= pat_step_nxt;
    end
  end

  // Result from the post-update state
  always_comb begin
    wifi_act = mode_nxt[LED_WIFI] != MODE_OFF && level_nxt[LED_WIFI];
    gcs_act  = mode_nxt[LED_GCS]  != MODE_OFF && level_nxt[LED_GCS];
    air_act  = mode_nxt[LED_AIR]  != MODE_OFF && level_nxt[LED_AIR];
    result   = '0;
    if (cfg.rgb_mode) begin
      if (wifi_act) begin
        result.green = PIXEL_ON;
      end else if (gcs_act) begin
        result.red = PIXEL_ON;
      end else if (air_act) begin
        result.blue = PIXEL_ON;
      end
    end else begin
      result.gcs_pin  = level_nxt[LED_GCS];
      result.wifi_pin = level_nxt[LED_WIFI];
      result.air_pin  = level_nxt[LED_AIR];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/status_led_blink_sequencer.sv =====
// Top level: request/result stream channels, APB register port, result buffer.
// Depends on slbs_pkg and slbs_core.
`default_nettype none

// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/tready     tuser: req_type; tdata: led_select, led_mode
// out_     out  out_tvalid/tready    tdata: pins, red, green, blue
// cfg_     in   APB, pready tied 1   0x0 cycle_time, 0x4 rgb_mode
//
// One request per cycle while in_tready is high; each result is registered
// in the output register, or in the skid entry while the output waits. The
// LED state updates at accept; the result goes to a two-entry buffer (output
// register plus skid), so a request is still taken while one result waits.
// in_tready drops only when both entries hold results. Reset (rst_n,
// synchronous) clears modes, levels and timers; cycle_time returns to 600 and rgb_mode to 0.

module status_led_blink_sequencer #(
  parameter int TIMER_BITS = slbs_pkg::TIMER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [1:0] led_select, [3:2] led_mode
  input  wire logic        in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [0] gcs_pin, [1] wifi_pin, [2] air_pin,
                                       // [10:3] red, [18:11] green, [26:19] blue
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import slbs_pkg::*;

  logic [CYCLE_W-1:0] cycle_time_r, third_r;
  logic               rgb_mode_r;
  logic               cfg_wr;
  logic               reg_idx;
  logic [32:0]        third_prod;
  slbs_cfg_t          cfg;

  logic               in_fire;
  slbs_result_t       result;
  slbs_result_t       main_r, skid_r;
  logic               main_valid_r, skid_valid_r;

  // ---- register port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[2];
  // third of the period computed once, when the period is written
  assign third_prod = 33'(cfg_pwdata[CYCLE_W-1:0]) * 33'(RECIP3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_time_r <= 16'd600;
      third_r      <= 16'd200;
      rgb_mode_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CYCLE_TIME: begin
          cycle_time_r <= cfg_pwdata[CYCLE_W-1:0];
          third_r      <= third_prod[RECIP3_SH +: CYCLE_W];
        end
        REG_RGB_MODE: rgb_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CYCLE_TIME: cfg_prdata = {16'd0, cycle_time_r};
      REG_RGB_MODE:   cfg_prdata = {31'd0, rgb_mode_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.cycle_time = cycle_time_r;
  assign cfg.third      = third_r;
  assign cfg.rgb_mode   = rgb_mode_r;

  // ---- request side ----
  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;

  slbs_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (in_fire),
    .req_type   (in_tuser),
    .led_select (in_tdata[1:0]),
    .led_mode   (in_tdata[3:2]),
    .cfg        (cfg),
    .result     (result)
  );

  // ---- result buffer: output register with skid entry ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_tready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_tready) begin
      main_r <= skid_valid_r ? skid_r : result;
    end
    if (main_valid_r && !out_tready && in_fire) begin
      skid_r <= result;
    end
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = {5'd0, main_r};

endmodule

`default_nettype wire
